[rtl/calibration_table_interpolator_macros.svh]
// Assertion macros shared by the calibration table interpolator.
`ifndef CALIBRATION_TABLE_INTERPOLATOR_MACROS_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CTI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CTI_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/cti_pkg.sv]
// Package with the item types and codes of the calibration table interpolator.
`timescale 1ns / 1ps
package cti_pkg;
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FEW   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [23:0] point_step;
      logic [31:0]        wavelength;
   } req_type;

   typedef struct packed {
      logic signed [23:0] step_out;
      logic [1:0]         status;
      logic [6:0]         points_held;
   } rsp_type;
endpackage

[rtl/cti_divider.sv]
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module cti_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [56:0] dividend,
   input  logic [31:0]        divisor,
   output logic               busy,
   output logic               done,
   output logic signed [56:0] quotient
);
   import cti_pkg::*;

   logic [56:0] mag_ff, mag_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   assign trial = {rem_ff[31:0], mag_ff[56]} - {1'b0, dvs_ff};

   // One shift-subtract step per cycle over the dividend magnitude.
   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = dividend[56] ? 57'(-dividend) : dividend;
         neg_in  = dividend[56];
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = 6'd57;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            mag_in = {mag_ff[55:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], mag_ff[56]};
            mag_in = {mag_ff[55:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? 57'(-mag_ff) : mag_ff;
endmodule

[rtl/calibration_table_interpolator.sv]
// Top level of the calibration table interpolator: table memory and sequencer.
`timescale 1ns / 1ps
// The table is held in one synchronous memory of MAX_POINTS entries, each
// holding a step and a wavelength, read through a registered port. One item
// is handled at a time. A clear resets the point count. An insert walks
// down from the top of the table, reading and moving one entry at a time
// until the free slot is at the insert position. A query reads the
// entries in order at one entry per cycle until a matching segment is
// found, then, unless the segment has zero width, runs a 57-step
// bit-serial division. The result waits in an output register while
// the next item is accepted.
module calibration_table_interpolator #(
   parameter int MAX_POINTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cti_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cti_pkg::rsp_type  rsp_data
);
   import cti_pkg::*;
   `include "calibration_table_interpolator_macros.svh"

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_IRD  = 4'd1;
   localparam logic [3:0] S_IWT  = 4'd2;
   localparam logic [3:0] S_QRD  = 4'd3;
   localparam logic [3:0] S_QWT  = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;

   // Table memory: one write port, one registered read port.
   logic [55:0] mem [MAX_POINTS];
   logic        we;
   logic [AW-1:0] waddr, raddr;
   logic [55:0] wdata, rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   req_type     item_ff, item_in;
   logic signed [23:0] sa_ff, sa_in;
   logic [31:0] wa_ff, wa_in;
   logic        have_ff, have_in;
   rsp_type     out_ff, out_in;
   logic        ov_ff, ov_in;
   logic        pend_ff, pend_in;
   rsp_type     pres_ff, pres_in;

   logic signed [23:0] rstep;
   logic [31:0] rwave;
   logic signed [24:0] dstep;
   logic [31:0] dw, off;
   logic signed [56:0] prod, quo;
   logic        div_start;
   logic        div_busy;
   logic        div_done;

   assign rstep = rdata_ff[55:32];
   assign rwave = rdata_ff[31:0];
   assign dstep = 25'(rstep) - 25'(sa_ff);
   assign dw    = rwave - wa_ff;
   assign off   = item_ff.wavelength - wa_ff;
   assign prod  = 57'(dstep) * $signed({25'd0, off});

   cti_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (dw),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quo)
   );

   assign req_stall = (state_ff != S_IDLE) || pend_ff;

   // Sequencer for clear, insert and query.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      item_in  = item_ff;
      sa_in    = sa_ff;
      wa_in    = wa_ff;
      have_in  = have_ff;
      pend_in  = pend_ff;
      pres_in  = pres_ff;
      we       = 1'b0;
      waddr    = idx_ff[AW-1:0];
      wdata    = {item_ff.point_step, item_ff.wavelength};
      raddr    = idx_ff[AW-1:0];
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !pend_ff) begin
               item_in = req_data;
               case (req_data.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     pres_in  = '{24'sd0, ST_OK, 7'd0};
                     pend_in  = 1'b1;
                  end
                  ACT_INSERT: begin
                     if (count_ff >= CW'(MAX_POINTS)) begin
                        pres_in = '{24'sd0, ST_FULL, 7'(count_ff)};
                        pend_in = 1'b1;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_IRD;
                     end
                  end
                  ACT_QUERY: begin
                     if (count_ff < CW'(2)) begin
                        pres_in = '{24'sd0, ST_FEW, 7'(count_ff)};
                        pend_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        have_in  = 1'b0;
                        state_in = S_QRD;
                     end
                  end
                  default: begin
                     pres_in = '{24'sd0, ST_OK, 7'(count_ff)};
                     pend_in = 1'b1;
                  end
               endcase
            end
         end
         S_IRD: begin
            // idx is the free slot; examine entry idx-1.
            if (idx_ff == '0) begin
               we       = 1'b1;
               count_in = count_ff + CW'(1);
               pres_in  = '{24'sd0, ST_OK, 7'(count_ff + CW'(1))};
               pend_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               raddr    = AW'(idx_ff - CW'(1));
               state_in = S_IWT;
            end
         end
         S_IWT: begin
            if (rstep > item_ff.point_step) begin
               we       = 1'b1;
               wdata    = rdata_ff;
               idx_in   = idx_ff - CW'(1);
               state_in = S_IRD;
            end else begin
               we       = 1'b1;
               count_in = count_ff + CW'(1);
               pres_in  = '{24'sd0, ST_OK, 7'(count_ff + CW'(1))};
               pend_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_QRD: begin
            state_in = S_QWT;
         end
         S_QWT: begin
            sa_in   = rstep;
            wa_in   = rwave;
            have_in = 1'b1;
            if (have_ff && wa_ff <= item_ff.wavelength && item_ff.wavelength <= rwave) begin
               if (dw == 32'd0) begin
                  pres_in  = '{sa_ff, ST_OK, 7'(count_ff)};
                  pend_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  sa_in     = sa_ff;
                  wa_in     = wa_ff;
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else if (idx_ff + CW'(1) >= count_ff) begin
               pres_in  = '{24'sd0, ST_RANGE, 7'(count_ff)};
               pend_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               raddr    = AW'(idx_ff + CW'(1));
               state_in = S_QWT;
            end
         end
         S_DIV: begin
            if (div_done) begin
               pres_in  = '{24'(sa_ff + 24'(quo)), ST_OK, 7'(count_ff)};
               pend_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // Hand the pending result to the output register.
      if (pend_ff && (!ov_ff || !rsp_stall)) begin
         pend_in = 1'b0;
      end
   end

   // Output register.
   always_comb begin
      ov_in  = ov_ff;
      out_in = out_ff;
      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end
      if (pend_ff && (!ov_ff || !rsp_stall)) begin
         ov_in  = 1'b1;
         out_in = pres_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      item_ff <= item_in;
      sa_ff   <= sa_in;
      wa_ff   <= wa_in;
      have_ff <= have_in;
      pres_ff <= pres_in;
      out_ff  <= out_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   `CTI_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CW'(MAX_POINTS), "count over max")
   `CTI_ASSERT_IMP(a_div_state, clock, reset, div_busy, state_ff == S_DIV, "divider busy outside")
   `CTI_ASSERT_NEXT(a_out_hold, clock, reset, ov_ff && rsp_stall, ov_ff && $stable(out_ff), "output lost")
   `CTI_ASSERT_IMP(a_no_accept, clock, reset, pend_ff, req_stall, "accepted with pending result")
endmodule
